// File: rtl/core/edd_pkg.sv
package edd_pkg;

  // Pixel channel and result widths
  localparam int CHAN_W    = 16;
  localparam int LEVEL_W   = 8;
  localparam int STEPS_W   = 8;
  localparam int NUM_CHAN  = 3;

  // Defaults handed to the top level parameters
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_FRAC_BITS = 16;

  // Step count after reset
  localparam logic [STEPS_W-1:0] STEPS_RESET = 8'd1;

  // Channel order inside packed error words
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

endpackage

// File: rtl/core/edd_ram.sv
module edd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read-first: a same-edge write is not seen by the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/edd_chan.sv
module edd_chan #(
  parameter int FRAC_BITS = 16
) (
  input  logic [FRAC_BITS+7:0]       scaled,
  input  logic [FRAC_BITS-1:0]       line_err,
  input  logic [FRAC_BITS-1:0]       right_err,
  input  logic [FRAC_BITS-1:0]       pend_err,
  input  logic [FRAC_BITS-1:0]       dr_err,
  input  logic                       first_col,
  input  logic [edd_pkg::STEPS_W-1:0] steps,
  output logic [edd_pkg::LEVEL_W-1:0] level,
  output logic [FRAC_BITS-1:0]       line_wr,
  output logic [FRAC_BITS-1:0]       pend_nxt,
  output logic [FRAC_BITS-1:0]       dr_nxt,
  output logic [FRAC_BITS-1:0]       right_nxt
);
  import edd_pkg::*;

  localparam int F = FRAC_BITS;

  logic [F+8:0] sum;
  logic [8:0]   whole;
  logic [F-1:0] frac;
  logic [F+2:0] m7;
  logic [F+2:0] m5;
  logic [F+1:0] m3;
  logic [F-1:0] r7;
  logic [F-1:0] d5;
  logic [F-1:0] l3;
  logic [F-1:0] d8;

  always_comb begin
    sum   = {1'b0, scaled} + (F+9)'(line_err) + (F+9)'(right_err);
    whole = sum[F+8:F];
    frac  = sum[F-1:0];

    // Floored 7/16, 5/16, 3/16 and 8/16 of the remainder by shift-add
    m7 = {frac, 3'b000} - {3'b000, frac};
    m5 = {1'b0, frac, 2'b00} + {3'b000, frac};
    m3 = {frac, 1'b0} + {2'b00, frac};
    r7 = F'(m7[F+2:4]);
    d5 = F'(m5[F+2:4]);
    l3 = F'(m3[F+1:4]);
    d8 = F'(frac[F-1:1]);

    if (whole > {1'b0, steps}) begin
      level = steps;
    end else begin
      level = whole[LEVEL_W-1:0];
    end

    line_wr   = pend_err + l3;
    right_nxt = r7;
    if (first_col) begin
      pend_nxt = d8 + dr_err;
      dr_nxt   = frac - d8 - r7;
    end else begin
      pend_nxt = d5 + dr_err;
      dr_nxt   = frac - d5 - l3 - r7;
    end
  end

endmodule

// File: rtl/core/error_diffusion_dither_unit.sv
// Path from input transaction to result: input stage, then result register.
// Throughput: 1 pixel per cycle while the output is not stalled; line buffer has one write and one read port,
//   the row-end write of a row's last down error is deferred to the next cycle.
// Reset (rst_n, synchronous): step count = 1, column 0, first-row flag set,
//   all row errors cleared; the line buffer is not cleared and reads as zero on the first row.
module error_diffusion_dither_unit #(
  parameter int MAX_WIDTH = edd_pkg::DEF_MAX_WIDTH,
  parameter int FRAC_BITS = edd_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [edd_pkg::STEPS_W-1:0] cfg_data,
  // pixel input
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [edd_pkg::CHAN_W-1:0]  in_red_in,
  input  logic [edd_pkg::CHAN_W-1:0]  in_green_in,
  input  logic [edd_pkg::CHAN_W-1:0]  in_blue_in,
  input  logic [edd_pkg::CHAN_W-1:0]  in_alpha_in,
  input  logic                        in_frame_start,
  input  logic                        in_row_end,
  // result output
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [edd_pkg::LEVEL_W-1:0] out_red_level,
  output logic [edd_pkg::LEVEL_W-1:0] out_green_level,
  output logic [edd_pkg::LEVEL_W-1:0] out_blue_level,
  output logic [edd_pkg::CHAN_W-1:0]  out_alpha_out,
  output logic                        out_row_last
);
  import edd_pkg::*;

  localparam int F     = FRAC_BITS;
  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int LW    = NUM_CHAN * F;
  localparam int SW    = F + 8;
  localparam int PW    = CHAN_W + STEPS_W;
  localparam logic [AW-1:0] LAST_COL = AW'(MAX_WIDTH - 1);

  // ---------------------------------------------------------------------
  // Configuration: single step-count register, always ready
  // ---------------------------------------------------------------------
  logic [STEPS_W-1:0] steps_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= STEPS_RESET;
    end else if (cfg_valid) begin
      steps_r <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: stage 1 holds the accepted pixel, the result register
  // decouples the output side so a new pixel enters while a result waits.
  // ---------------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s1_move;
  logic in_acc;

  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Front end: column tracking and row-end detection happen at accept so
  // the line buffer read address is issued as the pixel is accepted, ahead of the math.
  // ---------------------------------------------------------------------
  logic [AW-1:0] col_r, col_nxt;
  logic          frow_r, frow_nxt;
  logic [AW-1:0] in_x;
  logic          in_fr;
  logic          in_end;

  always_comb begin
    in_x  = in_frame_start ? '0 : col_r;
    in_fr = in_frame_start ? 1'b1 : frow_r;
    // Force a row end at the last buffer column
    in_end = in_row_end || (in_x == LAST_COL);
    col_nxt  = col_r;
    frow_nxt = frow_r;
    if (in_acc) begin
      col_nxt  = in_end ? '0 : in_x + AW'(1);
      frow_nxt = in_end ? 1'b0 : in_fr;
    end
  end

  // Scale each channel by the step count into level units
  logic [SW-1:0] in_scaled [NUM_CHAN];
  logic [CHAN_W-1:0] in_chan [NUM_CHAN];

  assign in_chan[CH_RED]   = in_red_in;
  assign in_chan[CH_GREEN] = in_green_in;
  assign in_chan[CH_BLUE]  = in_blue_in;

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      logic [PW-1:0]   prod;
      logic [PW+F-1:0] ext;
      prod = PW'(in_chan[c]) * PW'(steps_r);
      ext  = {prod, {F{1'b0}}};
      in_scaled[c] = ext[PW+F-1:CHAN_W];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1 registers
  // ---------------------------------------------------------------------
  logic [SW-1:0]     s1_scaled_r [NUM_CHAN];
  logic [CHAN_W-1:0] s1_alpha_r;
  logic              s1_row_end_r;
  logic [AW-1:0]     s1_x_r;
  logic              s1_end_r;
  logic              s1_fr_r;
  logic              s1_fs_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_scaled_r  <= in_scaled;
      s1_alpha_r   <= in_alpha_in;
      s1_row_end_r <= in_row_end;
      s1_x_r       <= in_x;
      s1_end_r     <= in_end;
      s1_fr_r      <= in_fr;
      s1_fs_r      <= in_frame_start;
    end
  end

  // ---------------------------------------------------------------------
  // Line buffer of down errors, one packed word per column
  // ---------------------------------------------------------------------
  logic          we_main;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [LW-1:0] ram_wdata;
  logic [LW-1:0] ram_rdata;
  logic [LW-1:0] line_wr_pk;
  logic [LW-1:0] pend_new_pk;

  logic          def_valid_r, def_valid_nxt;
  logic [AW-1:0] def_addr_r;
  logic [LW-1:0] def_data_r;

  // Main write lands on the column to the left; the row-end write of the
  // current column is held and committed on the next cycle, when the
  // following pixel sits in column 0 and leaves the port free.
  assign we_main   = s1_move && (s1_x_r != '0);
  assign ram_we    = we_main || def_valid_r;
  assign ram_waddr = we_main ? s1_x_r - AW'(1) : def_addr_r;
  assign ram_wdata = we_main ? line_wr_pk : def_data_r;
  assign def_valid_nxt = s1_move && s1_end_r;

  edd_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (in_x),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (s1_move && s1_end_r) begin
      def_addr_r <= s1_x_r;
      def_data_r <= pend_new_pk;
    end
  end

  // Forward writes that the registered read missed: the one on the edge the
  // pixel enters, and any that land while it waits in stage 1. A held
  // row-end write still in flight this cycle comes straight from its register.
  logic          ovr_valid_r;
  logic [LW-1:0] ovr_data_r;
  logic [LW-1:0] line_eff;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ovr_valid_r <= ram_we && (ram_waddr == in_x);
      ovr_data_r  <= ram_wdata;
    end else if (s1_valid_r && ram_we && (ram_waddr == s1_x_r)) begin
      ovr_valid_r <= 1'b1;
      ovr_data_r  <= ram_wdata;
    end
  end

  assign line_eff = (def_valid_r && (def_addr_r == s1_x_r)) ? def_data_r :
                    ovr_valid_r ? ovr_data_r : ram_rdata;

  // ---------------------------------------------------------------------
  // Per-channel diffusion
  // ---------------------------------------------------------------------
  logic [F-1:0] right_r [NUM_CHAN];
  logic [F-1:0] pend_r  [NUM_CHAN];
  logic [F-1:0] dr_r    [NUM_CHAN];
  logic [F-1:0] right_nxt [NUM_CHAN];
  logic [F-1:0] pend_nxt  [NUM_CHAN];
  logic [F-1:0] dr_nxt    [NUM_CHAN];
  logic [F-1:0] ch_right_new [NUM_CHAN];
  logic [F-1:0] ch_pend_new  [NUM_CHAN];
  logic [F-1:0] ch_dr_new    [NUM_CHAN];
  logic [F-1:0] ch_line_wr   [NUM_CHAN];
  logic [F-1:0] use_line     [NUM_CHAN];
  logic [F-1:0] use_right    [NUM_CHAN];
  logic [F-1:0] use_pend     [NUM_CHAN];
  logic [F-1:0] use_dr       [NUM_CHAN];
  logic [LEVEL_W-1:0] ch_level [NUM_CHAN];

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    // First row reads the buffer as zero; frame start drops row errors
    assign use_line[c]  = s1_fr_r ? '0 : line_eff[c*F +: F];
    assign use_right[c] = s1_fs_r ? '0 : right_r[c];
    assign use_pend[c]  = s1_fs_r ? '0 : pend_r[c];
    assign use_dr[c]    = s1_fs_r ? '0 : dr_r[c];

    edd_chan #(
      .FRAC_BITS (F)
    ) u_chan (
      .scaled    (s1_scaled_r[c]),
      .line_err  (use_line[c]),
      .right_err (use_right[c]),
      .pend_err  (use_pend[c]),
      .dr_err    (use_dr[c]),
      .first_col (s1_x_r == '0),
      .steps     (steps_r),
      .level     (ch_level[c]),
      .line_wr   (ch_line_wr[c]),
      .pend_nxt  (ch_pend_new[c]),
      .dr_nxt    (ch_dr_new[c]),
      .right_nxt (ch_right_new[c])
    );

    assign line_wr_pk[c*F +: F]  = ch_line_wr[c];
    assign pend_new_pk[c*F +: F] = ch_pend_new[c];
  end

  always_comb begin
    right_nxt = right_r;
    pend_nxt  = pend_r;
    dr_nxt    = dr_r;
    if (s1_move) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        // Row end clears the row errors in the same update that captures the last down error for the held write
        right_nxt[c] = s1_end_r ? '0 : ch_right_new[c];
        pend_nxt[c]  = s1_end_r ? '0 : ch_pend_new[c];
        dr_nxt[c]    = s1_end_r ? '0 : ch_dr_new[c];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic [LEVEL_W-1:0] red_r, green_r, blue_r;
  logic [CHAN_W-1:0]  alpha_r;
  logic               last_r;

  always_ff @(posedge clk) begin
    if (s1_move) begin
      red_r   <= ch_level[CH_RED];
      green_r <= ch_level[CH_GREEN];
      blue_r  <= ch_level[CH_BLUE];
      alpha_r <= s1_alpha_r;
      last_r  <= s1_row_end_r;
    end
  end

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      frow_r      <= 1'b1;
      def_valid_r <= 1'b0;
      for (int c = 0; c < NUM_CHAN; c++) begin
        right_r[c] <= '0;
        pend_r[c]  <= '0;
        dr_r[c]    <= '0;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
      frow_r      <= frow_nxt;
      def_valid_r <= def_valid_nxt;
      right_r     <= right_nxt;
      pend_r      <= pend_nxt;
      dr_r        <= dr_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red_level   = red_r;
  assign out_green_level = green_r;
  assign out_blue_level  = blue_r;
  assign out_alpha_out   = alpha_r;
  assign out_row_last    = last_r;

endmodule

// File: bench/error_diffusion_dither_unit_test.sv
`timescale 1ns / 1ps

module error_diffusion_dither_unit_test;
  import edd_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 9;
  localparam int MAX_W         = DEF_MAX_WIDTH;
  localparam int FRAC_W        = DEF_FRAC_BITS;
  localparam int MAX_IDLE      = 17;
  localparam int PHASE_PIXELS  = 72;    // 8 step settings; with the full-width row about 1800
  localparam int MAX_ROW_LEN   = 48;
  localparam int DRAIN_CYCLES  = 4;     // covers the input stage, result register and the deferred line write
  localparam int TIMEOUT_NS    = 8_000_000;
  localparam longint unsigned FRAC_MASK = (64'd1 << FRAC_W) - 1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              frame_start;
    logic              row_end;
  } pixel_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic [CHAN_W-1:0]  alpha;
    logic               row_last;
  } result_t;

  // One row of the opening table: either a pixel or a new step count
  typedef enum logic {ROW_PIXEL, ROW_STEPS} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [STEPS_W-1:0] steps;
    pixel_t             px;
    logic               typed;   // want holds a hand-computed result
    result_t            want;
  } case_t;

  localparam result_t NO_RESULT = '0;

  // Opening sequence, starting from the reset step count of 1. Hand-computed
  // results only where nothing has been diffused yet (first pixels of a frame).
  localparam case_t OPENING [22] = '{
    // frame start, black: no error anywhere yet
    '{ROW_PIXEL, 8'd0, '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0},
      1'b1, '{8'd0, 8'd0, 8'd0, 16'h0000, 1'b0}},
    // full scale after a zero remainder: still below one step
    '{ROW_PIXEL, 8'd0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0},
      1'b1, '{8'd0, 8'd0, 8'd0, 16'hFFFF, 1'b0}},
    '{ROW_PIXEL, 8'd0, '{16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 1'b0, 1'b0},
      1'b0, NO_RESULT},
    '{ROW_PIXEL, 8'd0, '{16'h5555, 16'hAAAA, 16'hFFFF, 16'hAAAA, 1'b0, 1'b1},
      1'b0, NO_RESULT},
    // second row reads the line buffer
    '{ROW_PIXEL, 8'd0, '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 1'b0, 1'b0},
      1'b0, NO_RESULT},
    '{ROW_PIXEL, 8'd0, '{16'h0001, 16'hFFFF, 16'h8000, 16'hFFFE, 1'b0, 1'b0},
      1'b0, NO_RESULT},
    '{ROW_PIXEL, 8'd0, '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h7FFF, 1'b0, 1'b0},
      1'b0, NO_RESULT},
    '{ROW_PIXEL, 8'd0, '{16'h3333, 16'hCCCC, 16'h5A5A, 16'h8000, 1'b0, 1'b1},
      1'b0, NO_RESULT},
    // unfinished row, dropped by the next frame start
    '{ROW_PIXEL, 8'd0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF, 1'b0, 1'b0},
      1'b0, NO_RESULT},
    '{ROW_PIXEL, 8'd0, '{16'h1234, 16'hFEDC, 16'h0F0F, 16'hFF00, 1'b0, 1'b0},
      1'b0, NO_RESULT},
    // one-pixel frame: start and row end together, errors cleared
    '{ROW_PIXEL, 8'd0, '{16'hFFFF, 16'h0000, 16'h8000, 16'hA5A5, 1'b1, 1'b1},
      1'b1, '{8'd0, 8'd0, 8'd0, 16'hA5A5, 1'b1}},
    '{ROW_STEPS, 8'd255, '0, 1'b0, NO_RESULT},
    // largest step count: full scale lands one level short
    '{ROW_PIXEL, 8'd0, '{16'hFFFF, 16'h0000, 16'h0101, 16'h8001, 1'b1, 1'b0},
      1'b1, '{8'd254, 8'd0, 8'd0, 16'h8001, 1'b0}},
    // keep pushing full scale to run into the saturation limit
    '{ROW_PIXEL, 8'd0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0},
      1'b0, NO_RESULT},
    '{ROW_PIXEL, 8'd0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1},
      1'b0, NO_RESULT},
    '{ROW_PIXEL, 8'd0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h1111, 1'b0, 1'b0},
      1'b0, NO_RESULT},
    '{ROW_PIXEL, 8'd0, '{16'h0000, 16'h8000, 16'hFFFF, 16'h2222, 1'b0, 1'b0},
      1'b0, NO_RESULT},
    '{ROW_PIXEL, 8'd0, '{16'hFFFF, 16'h7FFF, 16'h0001, 16'h3333, 1'b0, 1'b1},
      1'b0, NO_RESULT},
    // zero steps: only the stored errors remain
    '{ROW_STEPS, 8'd0, '0, 1'b0, NO_RESULT},
    '{ROW_PIXEL, 8'd0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h4444, 1'b0, 1'b0},
      1'b0, NO_RESULT},
    '{ROW_PIXEL, 8'd0, '{16'h8000, 16'hFFFF, 16'h0000, 16'h5555, 1'b0, 1'b1},
      1'b0, NO_RESULT},
    '{ROW_PIXEL, 8'd0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h1234, 1'b1, 1'b1},
      1'b1, '{8'd0, 8'd0, 8'd0, 16'h1234, 1'b1}}
  };

  // Clock, reset and every block input start from known values
  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 cfg_valid      = 1'b0;
  logic                 cfg_ready;
  logic [STEPS_W-1:0]   cfg_data       = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [CHAN_W-1:0]    in_red_in      = '0;
  logic [CHAN_W-1:0]    in_green_in    = '0;
  logic [CHAN_W-1:0]    in_blue_in     = '0;
  logic [CHAN_W-1:0]    in_alpha_in    = '0;
  logic                 in_frame_start = 1'b0;
  logic                 in_row_end     = 1'b0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [LEVEL_W-1:0]   out_red_level;
  logic [LEVEL_W-1:0]   out_green_level;
  logic [LEVEL_W-1:0]   out_blue_level;
  logic [CHAN_W-1:0]    out_alpha_out;
  logic                 out_row_last;

  error_diffusion_dither_unit #(
    .MAX_WIDTH(MAX_W),
    .FRAC_BITS(FRAC_W)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .in_alpha_in    (in_alpha_in),
    .in_frame_start (in_frame_start),
    .in_row_end     (in_row_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red_level  (out_red_level),
    .out_green_level(out_green_level),
    .out_blue_level (out_blue_level),
    .out_alpha_out  (out_alpha_out),
    .out_row_last   (out_row_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Dither state mirrored from the block: one line of down errors per
  // channel, the running right / pending-down / diagonal errors and position
  logic [STEPS_W-1:0] steps_now = STEPS_RESET;
  int unsigned        line_err [NUM_CHAN][MAX_W];
  bit                 line_written [MAX_W];
  int unsigned        right_err [NUM_CHAN];
  int unsigned        pend_err [NUM_CHAN];
  int unsigned        diag_err [NUM_CHAN];
  int unsigned        col = 0;
  bit                 top_row = 1'b1;

  result_t results_due [$];   // levels still owed by the block, oldest first
  int      fault_count    = 0;
  int      pixels_sent    = 0;
  int      results_seen   = 0;
  int      rows_seen      = 0;
  int      step_writes    = 0;
  bit      feed_calm      = 1'b0;

  // Quantize one pixel and diffuse its remainders, exactly as the block does
  function automatic void dither_pixel(input pixel_t px, output result_t res);
    longint unsigned    s, p, frac, r7, d5, l3, d8;
    logic [CHAN_W-1:0]  chan [NUM_CHAN];
    logic [LEVEL_W-1:0] lvl [NUM_CHAN];
    int unsigned        x;
    bit                 closes;
    chan[CH_RED]   = px.red;
    chan[CH_GREEN] = px.green;
    chan[CH_BLUE]  = px.blue;
    if (px.frame_start) begin
      col = 0;
      top_row = 1'b1;
      right_err = '{default: 0};
      pend_err  = '{default: 0};
      diag_err  = '{default: 0};
    end
    x = col;
    // the last column ends a row even without row_end
    closes = px.row_end || (x == MAX_W - 1);
    for (int c = 0; c < NUM_CHAN; c++) begin
      p = chan[c];
      s = ((p * steps_now) << FRAC_W) >> CHAN_W;
      if (!top_row) s += line_err[c][x];
      s += right_err[c];
      frac = s & FRAC_MASK;
      lvl[c] = ((s >> FRAC_W) > steps_now) ? steps_now : LEVEL_W'(s >> FRAC_W);
      r7 = (7 * frac) >> 4;
      if (x != 0) begin
        d5 = (5 * frac) >> 4;
        l3 = (3 * frac) >> 4;
        line_err[c][x - 1] = 32'(pend_err[c] + l3);
        line_written[x - 1] = 1'b1;
        pend_err[c] = 32'(d5 + diag_err[c]);
        diag_err[c] = 32'(frac - d5 - l3 - r7);
      end else begin
        d8 = (8 * frac) >> 4;
        pend_err[c] = 32'(d8 + diag_err[c]);
        diag_err[c] = 32'(frac - d8 - r7);
      end
      right_err[c] = 32'(r7);
    end
    if (closes) begin
      for (int c = 0; c < NUM_CHAN; c++) line_err[c][x] = pend_err[c];
      line_written[x] = 1'b1;
      right_err = '{default: 0};
      pend_err  = '{default: 0};
      diag_err  = '{default: 0};
      col = 0;
      top_row = 1'b0;
    end else begin
      col = x + 1;
    end
    res = '{lvl[CH_RED], lvl[CH_GREEN], lvl[CH_BLUE], px.alpha, px.row_end};
  endfunction

  // Idle cycles before the next transaction; flip now and then into a calm
  // stretch where no idling happens at all
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, MAX_IDLE));
  endfunction

  function automatic pixel_t draw_pixel();
    pixel_t px;
    px = '0;
    px.red   = ($urandom_range(0, 7) == 0) ? '0 : CHAN_W'($urandom);
    px.green = ($urandom_range(0, 7) == 0) ? '1 : CHAN_W'($urandom);
    px.blue  = ($urandom_range(0, 7) == 0) ? '1 : CHAN_W'($urandom);
    px.alpha = CHAN_W'($urandom);
    return px;
  endfunction

  // Present one pixel, hold it until accepted, then log what it must produce.
  // Enter and leave at a falling edge.
  task automatic send_pixel(input pixel_t px, input logic typed, input result_t want);
    int      gap;
    result_t due;
    gap = draw_wait(feed_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_red_in      <= px.red;
    in_green_in    <= px.green;
    in_blue_in     <= px.blue;
    in_alpha_in    <= px.alpha;
    in_frame_start <= px.frame_start;
    in_row_end     <= px.row_end;
    in_valid       <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    dither_pixel(px, due);
    results_due.push_back(typed ? want : due);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Random row of len pixels; fresh opens a frame, closed marks the last one
  task automatic send_row(input int len, input bit fresh, input bit closed);
    pixel_t px;
    for (int i = 0; i < len; i++) begin
      px = draw_pixel();
      px.frame_start = fresh && (i == 0);
      px.row_end = closed && (i == len - 1);
      send_pixel(px, 1'b0, NO_RESULT);
    end
  endtask

  // Change the step count only with nothing in flight
  task automatic write_steps(input logic [STEPS_W-1:0] value);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    steps_now = value;
    step_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    pixel_t             px;
    logic [STEPS_W-1:0] plan [8];
    int                 len, cap, rows, phase_mark, opening_count;
    bit                 fresh, broken;

    // Hold reset, then release it away from the sampling edge
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the opening table: extremes, frame and row markers, step counts
    foreach (OPENING[i]) begin
      if (OPENING[i].kind == ROW_STEPS) begin
        write_steps(OPENING[i].steps);
      end else begin
        send_pixel(OPENING[i].px, OPENING[i].typed, OPENING[i].want);
      end
    end
    opening_count = pixels_sent;

    // Random part: one phase per step count, extremes first
    plan = '{8'd255, 8'd0, 8'd1, 8'd3, 8'd16, 8'd128,
             8'($urandom_range(2, 254)), 8'($urandom_range(2, 254))};
    foreach (plan[k]) begin
      write_steps(plan[k]);
      phase_mark = pixels_sent;
      while (pixels_sent - phase_mark < PHASE_PIXELS) begin
        if ($urandom_range(0, 6) == 0) begin
          // Noise: loose markers, but never let a later row read a line
          // entry that no row has written yet
          repeat ($urandom_range(1, 8)) begin
            px = draw_pixel();
            px.frame_start = ($urandom_range(0, 15) == 0);
            px.row_end = ($urandom_range(0, 5) == 0);
            if (!px.frame_start && !top_row && !line_written[col]) px.frame_start = 1'b1;
            send_pixel(px, 1'b0, NO_RESULT);
          end
        end else begin
          // Well-formed frame of a few rows; now and then continue the
          // previous frame, and now and then cut the last row short
          rows = $urandom_range(1, 6);
          for (int r = 0; r < rows; r++) begin
            fresh = (r == 0) && ((col != 0) || ($urandom_range(0, 3) != 0));
            cap = 0;
            while (cap < MAX_ROW_LEN && line_written[cap]) cap++;
            if (fresh || top_row) cap = MAX_ROW_LEN;
            len = $urandom_range(1, cap);
            broken = (r == rows - 1) && ($urandom_range(0, 7) == 0);
            send_row(len, fresh, !broken);
          end
        end
      end
    end

    // Full-width row: it overruns, is closed internally at the last column,
    // and its tail becomes a short second row; one more row reads both
    write_steps(8'($urandom_range(1, 255)));
    send_row(MAX_W + 6, 1'b1, 1'b1);
    send_row(8, 1'b0, 1'b1);
    in_valid <= 1'b0;

    // Drain, then give the pipeline a few more cycles to show any extra result
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pixels (%0d in the opening table) over %0d step settings.",
             pixels_sent, opening_count, step_writes);
    $display("Checked %0d results, %0d of them closing a row.", results_seen, rows_seen);
    if (fault_count == 0) begin
      $display("error_diffusion_dither_unit_test passed");
    end else begin
      $display("error_diffusion_dither_unit_test failed");
    end
    $finish;
  end

  // Result side: stall a random number of cycles before taking each result
  initial begin : result_sink
    bit calm;
    int hold;
    calm = 1'b0;
    @(posedge rst_n);
    forever begin
      hold = draw_wait(calm);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Compare every accepted result with the oldest one owed
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_red_level, out_green_level, out_blue_level, out_alpha_out, out_row_last};
      results_seen++;
      if (got.row_last) rows_seen++;
      if (results_due.size() == 0) begin
        $error("result with nothing outstanding: red %0d green %0d blue %0d",
               got.red, got.green, got.blue);
        fault_count++;
      end else begin
        want = results_due.pop_front();
        if (got.red != want.red) begin
          $error("red_level: expected %0d, got %0d", want.red, got.red);
          fault_count++;
        end
        if (got.green != want.green) begin
          $error("green_level: expected %0d, got %0d", want.green, got.green);
          fault_count++;
        end
        if (got.blue != want.blue) begin
          $error("blue_level: expected %0d, got %0d", want.blue, got.blue);
          fault_count++;
        end
        if (got.alpha != want.alpha) begin
          $error("alpha_out: expected 0x%04h, got 0x%04h", want.alpha, got.alpha);
          fault_count++;
        end
        if (got.row_last != want.row_last) begin
          $error("row_last: expected %0d, got %0d", want.row_last, got.row_last);
          fault_count++;
        end
      end
    end
  end

  // Hard stop in case a handshake never completes
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("error_diffusion_dither_unit_test failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/edd_pkg.sv
rtl/core/edd_ram.sv
rtl/core/edd_chan.sv
rtl/core/error_diffusion_dither_unit.sv
bench/error_diffusion_dither_unit_test.sv
